[hw/rtl/tphb_pkg.sv]
// Shared types and constants for the trapezoid profile H-bridge PWM block.
// Holds the motor count, field widths and the structs to the serial divider.
// No dependencies.
package tphb_pkg;

	localparam int MOTOR_COUNT = 12;
	localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int DUTY_W      = 16;
	localparam int LEVEL_W     = 13;
	localparam int FULL_LEVEL  = 7500;

	typedef struct packed {
		logic              start;
		logic [DUTY_W-1:0] mag;
		logic [DUTY_W-1:0] mult;
		logic [DUTY_W-1:0] divisor;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [DUTY_W-1:0] quot;
	} md_rsp_t;

endpackage

[hw/rtl/tphb_muldiv.sv]
// Bit-serial unsigned multiply then divide: quot = mag * mult / divisor.
// One bit per cycle: shift-add for the multiply, then restoring division.
// Depends on tphb_pkg.
module tphb_muldiv import tphb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_MUL  = 3'b010,
		PH_DIV  = 3'b100
	} md_phase_t;

	localparam int CNT_W = $clog2(DUTY_W);

	md_phase_t         phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DUTY_W-1:0] hi_q;
	logic [DUTY_W-1:0] lo_q;
	logic [DUTY_W-1:0] mag_q;
	logic [DUTY_W-1:0] div_q;
	logic [DUTY_W:0]   mul_sum;
	logic [DUTY_W:0]   rem_sh;
	logic              rem_ge;
	logic [DUTY_W:0]   rem_sub;

	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mag_q} : '0);
	assign rem_sh  = {hi_q, lo_q[DUTY_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DUTY_W - 1)) begin
						phase_q <= PH_DIV;
					end
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DUTY_W - 1)) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					hi_q  <= '0;
					lo_q  <= req.mult;
					mag_q <= req.mag;
					div_q <= req.divisor;
				end
			end
			PH_MUL: begin
				hi_q <= mul_sum[DUTY_W:1];
				lo_q <= {mul_sum[0], lo_q[DUTY_W-1:1]};
			end
			PH_DIV: begin
				hi_q <= rem_ge ? rem_sub[DUTY_W-1:0] : rem_sh[DUTY_W-1:0];
				lo_q <= {lo_q[DUTY_W-2:0], rem_ge};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = lo_q;

endmodule

[hw/rtl/trapezoid_profile_hbridge_pwm.sv]
// Top level of the trapezoid profile H-bridge PWM player.
// Depends on tphb_pkg and tphb_muldiv.
//
// Each input beat on the s_ channel names a motor and an event (tick, start,
// stop, direct duty or brake); s_tuser carries the event kind. A beat causes
// at most one output beat on the m_ channel with the motor's two bridge
// levels and the applied duty; m_tlast marks the tick that ended a profile.
// The profile shape registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. One beat is worked on at a time. A tick
// in a ramp runs the serial multiply/divide unit, one bit per cycle, in
// ST_CALC before ST_SEND loads the output register. Every other event
// with an output goes straight from ST_IDLE to ST_SEND; an event without
// output leaves the block in ST_IDLE, ready to take the next input beat.
// The output beat sits in a register; while the receiver stalls, the next
// input beat is still taken and worked out, and then waits for the register.
// Reset clears every motor's position and running flag and loads the shape
// registers with length 1000, peak 10000, ramps of 200.
module trapezoid_profile_hbridge_pwm import tphb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // motor[3:0], duty[19:4], zero pad
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // motor_out[3:0], level_a[16:4], level_b[29:17],
	                               // applied_duty[45:30], zero pad
	output logic        m_tlast    // finished
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_START = 3'd1,
		KIND_STOP  = 3'd2,
		KIND_DUTY  = 3'd3,
		KIND_BRAKE = 3'd4
	} kind_t;

	localparam logic [1:0] REG_LENGTH    = 2'd0;
	localparam logic [1:0] REG_PEAK      = 2'd1;
	localparam logic [1:0] REG_RAMP_UP   = 2'd2;
	localparam logic [1:0] REG_RAMP_DOWN = 2'd3;

	state_t                   state_q;
	logic [15:0]              len_q;
	logic signed [DUTY_W-1:0] peak_q;
	logic [15:0]              up_q;
	logic [15:0]              down_q;
	logic [15:0]              pos_q [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0]   running_q;

	logic [3:0]               res_motor_q;
	logic signed [DUTY_W-1:0] res_duty_q;
	logic                     res_fin_q;
	logic                     res_brake_q;
	logic                     neg_q;
	logic                     fall_q;

	logic                     m_tvalid_q;
	logic [47:0]              m_tdata_q;
	logic                     m_tlast_q;

	kind_t                    kind;
	logic [3:0]               in_motor;
	logic signed [DUTY_W-1:0] in_duty;
	logic [MIDX_W-1:0]        midx;
	logic                     motor_ok;
	logic                     accept;
	logic [15:0]              pos_cur;
	logic [16:0]              sum_ad;
	logic                     has_cruise;
	logic [15:0]              cruise_end;
	logic                     tick_live;
	logic                     in_rise;
	logic                     in_cruise;
	logic                     need_div;
	logic [DUTY_W-1:0]        peak_mag;
	md_req_t                  md_req;
	md_rsp_t                  md_rsp;
	logic signed [DUTY_W:0]   quot_s;
	logic signed [DUTY_W:0]   prof_val;
	logic                     out_free;
	logic                     out_load;
	logic [DUTY_W:0]          duty_mag;
	logic [DUTY_W+2:0]        scaled;
	logic [LEVEL_W-1:0]       level;
	logic [LEVEL_W-1:0]       level_a;
	logic [LEVEL_W-1:0]       level_b;

	assign kind     = kind_t'(s_tuser);
	assign in_motor = s_tdata[3:0];
	assign in_duty  = s_tdata[19:4];
	assign midx     = in_motor[MIDX_W-1:0];
	assign motor_ok = {1'b0, in_motor} < 5'(MOTOR_COUNT);
	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid & s_tready;
	assign pos_cur  = pos_q[midx];

	// The cruise phase ends at L - D when the ramps leave room, else at A.
	assign sum_ad     = {1'b0, up_q} + {1'b0, down_q};
	assign has_cruise = {1'b0, len_q} > sum_ad;
	assign cruise_end = has_cruise ? (len_q - down_q) : up_q;
	assign tick_live  = kind == KIND_TICK && running_q[midx] && pos_cur < len_q;
	assign in_rise    = pos_cur < up_q;
	assign in_cruise  = pos_cur < cruise_end;
	assign need_div   = accept && motor_ok && tick_live &&
	                    (in_rise || (!in_cruise && down_q != '0));
	assign peak_mag   = peak_q[DUTY_W-1] ? (~peak_q + 1'b1) : peak_q;

	always_comb begin
		md_req.start   = need_div;
		md_req.mag     = peak_mag;
		md_req.mult    = in_rise ? pos_cur : (pos_cur - cruise_end);
		md_req.divisor = in_rise ? up_q : down_q;
	end

	tphb_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign quot_s   = neg_q ? -$signed({1'b0, md_rsp.quot}) : $signed({1'b0, md_rsp.quot});
	assign prof_val = fall_q ? ($signed({peak_q[DUTY_W-1], peak_q}) - quot_s) : quot_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= 16'd1000;
			peak_q  <= 16'sd10000;
			up_q    <= 16'd200;
			down_q  <= 16'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LENGTH:    len_q  <= cfg_data;
				REG_PEAK:      peak_q <= cfg_data;
				REG_RAMP_UP:   up_q   <= cfg_data;
				REG_RAMP_DOWN: down_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= '0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && motor_ok) begin
						unique case (kind)
							KIND_TICK: begin
								if (running_q[midx]) begin
									state_q <= need_div ? ST_CALC : ST_SEND;
									if (tick_live) begin
										pos_q[midx] <= pos_cur + 1'b1;
									end else begin
										running_q[midx] <= 1'b0;
									end
								end
							end
							KIND_START: begin
								pos_q[midx]     <= '0;
								running_q[midx] <= 1'b1;
							end
							KIND_STOP, KIND_DUTY: begin
								running_q[midx] <= 1'b0;
								state_q         <= ST_SEND;
							end
							KIND_BRAKE: state_q <= ST_SEND;
							default: ;
						endcase
					end
				end
				ST_CALC: begin
					if (md_rsp.done) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			res_motor_q <= in_motor;
			res_fin_q   <= kind == KIND_TICK && !tick_live;
			res_brake_q <= kind == KIND_BRAKE;
			neg_q       <= peak_q[DUTY_W-1];
			fall_q      <= !in_rise;
			if (kind == KIND_DUTY) begin
				res_duty_q <= in_duty;
			end else if (tick_live && in_cruise && !in_rise) begin
				res_duty_q <= peak_q;
			end else begin
				res_duty_q <= '0;
			end
		end else if (state_q == ST_CALC && md_rsp.done) begin
			res_duty_q <= prof_val[DUTY_W-1:0];
		end
	end

	// Level is |duty| * 3 / 4, which equals |duty| * 7500 / 10000 truncated.
	assign duty_mag = res_duty_q[DUTY_W-1] ? -{res_duty_q[DUTY_W-1], res_duty_q}
	                                       : {1'b0, res_duty_q};
	assign scaled   = {1'b0, duty_mag, 1'b0} + {2'b00, duty_mag};
	assign level    = (scaled[DUTY_W+2:2] > (DUTY_W+1)'(FULL_LEVEL)) ?
	                  LEVEL_W'(FULL_LEVEL) : scaled[LEVEL_W+1:2];
	assign level_a  = res_brake_q ? LEVEL_W'(FULL_LEVEL) :
	                  (!res_duty_q[DUTY_W-1] ? level : '0);
	assign level_b  = res_brake_q ? LEVEL_W'(FULL_LEVEL) :
	                  (res_duty_q[DUTY_W-1] ? level : '0);

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = state_q == ST_SEND && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, res_duty_q, level_b, level_a, res_motor_q};
			m_tlast_q <= res_fin_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for trapezoid_profile_hbridge_pwm: it sends motor events under random
// idling on both sides and checks every output beat against a predictor kept in this file.
// Depends on tphb_pkg and the RTL top level only.
module tb_top;
	import tphb_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int SETTLE_CYCLES  = 50;
	localparam int TIMEOUT_CYCLES = 500_000;
	localparam int RAND_ITEMS     = 675;
	localparam int PHASE_ITEMS    = 70;
	localparam int DUTY_SCALE     = 10000;

	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_START    = 3'd1;
	localparam logic [2:0] KIND_STOP     = 3'd2;
	localparam logic [2:0] KIND_DUTY     = 3'd3;
	localparam logic [2:0] KIND_BRAKE    = 3'd4;
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam logic [1:0] REG_LENGTH    = 2'd0;
	localparam logic [1:0] REG_PEAK      = 2'd1;
	localparam logic [1:0] REG_RAMP_UP   = 2'd2;
	localparam logic [1:0] REG_RAMP_DOWN = 2'd3;

	typedef struct packed {
		logic [3:0]         motor;
		logic [12:0]        lvl_a;
		logic [12:0]        lvl_b;
		logic signed [15:0] duty;
		logic               done;
	} bridge_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [3:0]         motor;
		logic signed [15:0] duty;
		logic               typed;
		logic               outcome;
		bridge_t            res;
	} dir_row_t;

	typedef struct packed {
		logic [15:0]        len;
		logic signed [15:0] peak;
		logic [15:0]        up;
		logic [15:0]        down;
	} shape_t;

	localparam bridge_t NO_OUT = '0;
	localparam logic signed [15:0] CORNER_DUTY [7] = '{16'sh8000, 16'sh7FFF, 16'sd0,
		16'sd10000, -16'sd10000, 16'sd13333, -16'sd13334};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_LENGTH;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // motor[3:0], duty[19:4], zero pad
	logic [2:0]  s_tuser   = KIND_TICK;   // kind[2:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;   // motor_out[3:0], level_a[16:4], level_b[29:17],
	                        // applied_duty[45:30], zero pad
	logic        m_tlast;   // finished

	logic [15:0]        shape_len  = 16'd1000;
	logic signed [15:0] shape_peak = 16'sd10000;
	logic [15:0]        shape_up   = 16'd200;
	logic [15:0]        shape_down = 16'd200;
	logic [15:0]        step_pos [MOTOR_COUNT];
	logic               armed    [MOTOR_COUNT];

	bridge_t  bridge_q [$];
	dir_row_t plan [25];
	shape_t   shape_plan [5];
	int       err_count  = 0;
	int       checked    = 0;
	int       ends_seen  = 0;
	int       live_items = 0;
	int       ignored    = 0;
	int       stall_left = 0;
	bit       tx_idle_on = 1'b1;
	bit       rx_idle_on = 1'b1;

	trapezoid_profile_hbridge_pwm dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Run timed out with %0d beats still expected.", bridge_q.size());
		$display("** trapezoid_profile_hbridge_pwm: FAILED **");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	function automatic logic signed [15:0] shape_at(input logic [15:0] pos);
		longint len, up, down, flat, pk, p;
		len  = shape_len;
		up   = shape_up;
		down = shape_down;
		pk   = shape_peak;
		p    = pos;
		flat = (len > up + down) ? len - up - down : 0;
		if (p < up)
			return 16'(pk * p / up);
		if (p < up + flat)
			return shape_peak;
		if (down == 0)
			return '0;
		return 16'(pk - pk * (p - up - flat) / down);
	endfunction

	function automatic bridge_t drive_levels(input logic [3:0] m, input logic signed [15:0] d);
		bridge_t r;
		longint  mag, lvl;
		r       = '0;
		r.motor = m;
		r.duty  = d;
		mag = d;
		if (mag < 0)
			mag = -mag;
		lvl = mag * FULL_LEVEL / DUTY_SCALE;
		if (lvl > FULL_LEVEL)
			lvl = FULL_LEVEL;
		if (d > 0)
			r.lvl_a = 13'(lvl);
		else if (d < 0)
			r.lvl_b = 13'(lvl);
		return r;
	endfunction

	function automatic bit predict_event(input logic [2:0] kind, input logic [3:0] m,
			input logic signed [15:0] d, output bridge_t r);
		r       = '0;
		r.motor = m;
		if (m >= MOTOR_COUNT)
			return 1'b0;
		case (kind)
			KIND_TICK: begin
				if (!armed[m])
					return 1'b0;
				if (step_pos[m] < shape_len) begin
					r = drive_levels(m, shape_at(step_pos[m]));
					step_pos[m] = step_pos[m] + 16'd1;
				end else begin
					armed[m] = 1'b0;
					r.done   = 1'b1;
				end
				return 1'b1;
			end
			KIND_START: begin
				step_pos[m] = '0;
				armed[m]    = 1'b1;
				return 1'b0;
			end
			KIND_STOP: begin
				armed[m] = 1'b0;
				return 1'b1;
			end
			KIND_DUTY: begin
				armed[m] = 1'b0;
				r = drive_levels(m, d);
				return 1'b1;
			end
			KIND_BRAKE: begin
				r.lvl_a = 13'(FULL_LEVEL);
				r.lvl_b = 13'(FULL_LEVEL);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic send_event(input logic [2:0] kind, input logic [3:0] m,
			input logic signed [15:0] d, input bit typed, input bit outcome, input bridge_t res);
		bridge_t pred;
		bit      got;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0000, d, m};
		do @(posedge clk); while (!s_tready);
		got = predict_event(kind, m, d, pred);
		if (got || (kind == KIND_START && m < MOTOR_COUNT))
			live_items++;
		else
			ignored++;
		if (typed) begin
			got  = outcome;
			pred = res;
		end
		if (got)
			bridge_q.push_back(pred);
	endtask

	task automatic write_shape(input shape_t sh);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LENGTH;
		cfg_data  <= sh.len;
		@(posedge clk);
		cfg_index <= REG_PEAK;
		cfg_data  <= sh.peak;
		@(posedge clk);
		cfg_index <= REG_RAMP_UP;
		cfg_data  <= sh.up;
		@(posedge clk);
		cfg_index <= REG_RAMP_DOWN;
		cfg_data  <= sh.down;
		@(posedge clk);
		cfg_we     <= 1'b0;
		shape_len  = sh.len;
		shape_peak = sh.peak;
		shape_up   = sh.up;
		shape_down = sh.down;
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 13);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		bridge_t seen, want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.motor = m_tdata[3:0];
			seen.lvl_a = m_tdata[16:4];
			seen.lvl_b = m_tdata[29:17];
			seen.duty  = m_tdata[45:30];
			seen.done  = m_tlast;
			if (seen.done)
				ends_seen++;
			if (bridge_q.size() == 0) begin
				flag_mismatch($sformatf("beat for motor %0d with nothing expected", seen.motor));
			end else begin
				want = bridge_q.pop_front();
				checked++;
				if (seen.motor !== want.motor)
					flag_mismatch($sformatf("motor %0d, expected %0d", seen.motor, want.motor));
				if (seen.lvl_a !== want.lvl_a)
					flag_mismatch($sformatf("motor %0d level_a %0d, expected %0d",
						want.motor, seen.lvl_a, want.lvl_a));
				if (seen.lvl_b !== want.lvl_b)
					flag_mismatch($sformatf("motor %0d level_b %0d, expected %0d",
						want.motor, seen.lvl_b, want.lvl_b));
				if (seen.duty !== want.duty)
					flag_mismatch($sformatf("motor %0d applied_duty %0d, expected %0d",
						want.motor, seen.duty, want.duty));
				if (seen.done !== want.done)
					flag_mismatch($sformatf("motor %0d finished %0b, expected %0b",
						want.motor, seen.done, want.done));
			end
		end
	end

	initial begin
		shape_t             sh;
		logic [2:0]         kind;
		logic [3:0]         m, focus_a, focus_b;
		logic signed [15:0] d;
		int                 r, phase, phase_start;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			step_pos[i] = '0;
			armed[i]    = 1'b0;
		end
		plan = '{
			'{KIND_TICK,     4'd0,  16'sd0,      1'b1, 1'b0, NO_OUT},
			'{KIND_BRAKE,    4'd0,  16'sd0,      1'b1, 1'b1,
				'{4'd0, 13'd7500, 13'd7500, 16'sd0, 1'b0}},
			'{KIND_STOP,     4'd11, 16'sd0,      1'b1, 1'b1, '{4'd11, 13'd0, 13'd0, 16'sd0, 1'b0}},
			'{KIND_DUTY,     4'd1,  16'sh7FFF,   1'b1, 1'b1,
				'{4'd1, 13'd7500, 13'd0, 16'sh7FFF, 1'b0}},
			'{KIND_DUTY,     4'd2,  16'sh8000,   1'b1, 1'b1,
				'{4'd2, 13'd0, 13'd7500, 16'sh8000, 1'b0}},
			'{KIND_DUTY,     4'd3,  16'sd0,      1'b1, 1'b1, '{4'd3, 13'd0, 13'd0, 16'sd0, 1'b0}},
			'{KIND_DUTY,     4'd4,  16'sd1,      1'b1, 1'b1, '{4'd4, 13'd0, 13'd0, 16'sd1, 1'b0}},
			'{KIND_DUTY,     4'd5,  -16'sd10000, 1'b1, 1'b1,
				'{4'd5, 13'd0, 13'd7500, -16'sd10000, 1'b0}},
			'{KIND_DUTY,     4'd6,  16'sd4000,   1'b1, 1'b1,
				'{4'd6, 13'd3000, 13'd0, 16'sd4000, 1'b0}},
			'{KIND_SPARE_LO, 4'd0,  16'sd0,      1'b1, 1'b0, NO_OUT},
			'{KIND_SPARE_HI, 4'd1,  16'sh5A5A,   1'b1, 1'b0, NO_OUT},
			'{KIND_BRAKE,    4'd12, 16'sd0,      1'b1, 1'b0, NO_OUT},
			'{KIND_DUTY,     4'd15, -16'sd1,     1'b1, 1'b0, NO_OUT},
			'{KIND_START,    4'd7,  16'sd0,      1'b1, 1'b0, NO_OUT},
			'{KIND_TICK,     4'd7,  16'sd0,      1'b1, 1'b1, '{4'd7, 13'd0, 13'd0, 16'sd0, 1'b0}},
			'{KIND_TICK,     4'd7,  16'sd0,      1'b0, 1'b0, NO_OUT},
			'{KIND_TICK,     4'd7,  16'sd0,      1'b0, 1'b0, NO_OUT},
			'{KIND_BRAKE,    4'd7,  16'sd0,      1'b1, 1'b1,
				'{4'd7, 13'd7500, 13'd7500, 16'sd0, 1'b0}},
			'{KIND_TICK,     4'd7,  16'sd0,      1'b0, 1'b0, NO_OUT},
			'{KIND_START,    4'd8,  16'sd0,      1'b1, 1'b0, NO_OUT},
			'{KIND_STOP,     4'd8,  16'sd0,      1'b1, 1'b1, '{4'd8, 13'd0, 13'd0, 16'sd0, 1'b0}},
			'{KIND_TICK,     4'd8,  16'sd0,      1'b1, 1'b0, NO_OUT},
			'{KIND_DUTY,     4'd7,  -16'sd20000, 1'b1, 1'b1,
				'{4'd7, 13'd0, 13'd7500, -16'sd20000, 1'b0}},
			'{KIND_TICK,     4'd7,  16'sd0,      1'b1, 1'b0, NO_OUT},
			'{KIND_SPARE_LO + 3'd1, 4'd9, 16'sd0, 1'b1, 1'b0, NO_OUT}
		};
		shape_plan = '{
			'{16'd0,     16'sd10000, 16'd0,     16'd0},
			'{16'd20,    16'sh8000,  16'd5,     16'd0},
			'{16'd12,    16'sh7FFF,  16'd10,    16'd10},
			'{16'hFFFF,  -16'sd1,    16'hFFFF,  16'hFFFF},
			'{16'd30,    16'sd7,     16'd3,     16'd4}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_event(plan[i].kind, plan[i].motor, plan[i].duty, plan[i].typed,
				plan[i].outcome, plan[i].res);

		phase_start = live_items + ignored;
		phase = 0;
		while (live_items + ignored - phase_start < RAND_ITEMS) begin
			// Shape changes only once the block has drained.
			s_tvalid <= 1'b0;
			while (bridge_q.size() != 0) @(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (phase < 5) begin
				sh = shape_plan[phase];
			end else begin
				sh.len  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48));
				sh.peak = 16'($urandom);
				sh.up   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
				sh.down = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
			end
			write_shape(sh);
			tx_idle_on = (phase % 4 != 3) &&
				(live_items + ignored - phase_start < RAND_ITEMS - 140);
			rx_idle_on = tx_idle_on;
			focus_a = 4'($urandom_range(0, MOTOR_COUNT - 1));
			focus_b = 4'($urandom_range(0, MOTOR_COUNT - 1));
			r = live_items + ignored;
			while (live_items + ignored - r < PHASE_ITEMS &&
					live_items + ignored - phase_start < RAND_ITEMS) begin
				if ($urandom_range(0, 5) != 0)
					m = $urandom_range(0, 1) ? focus_a : focus_b;
				else
					m = 4'($urandom_range(0, MOTOR_COUNT - 1));
				d = ($urandom_range(0, 4) == 0) ? CORNER_DUTY[$urandom_range(0, 6)]
					: 16'($urandom);
				case ($urandom_range(0, 99)) inside
					[0:3]: begin
						kind = 3'($urandom_range(0, 7));
						if (MOTOR_COUNT < 16)
							m = 4'($urandom_range(MOTOR_COUNT, 15));
					end
					[4:6]: kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
					default: begin
						if (!armed[m] && $urandom_range(0, 1))
							kind = KIND_START;
						else case ($urandom_range(0, 99)) inside
							[0:71]:  kind = KIND_TICK;
							[72:77]: kind = KIND_START;
							[78:83]: kind = KIND_STOP;
							[84:91]: kind = KIND_DUTY;
							default: kind = KIND_BRAKE;
						endcase
					end
				endcase
				send_event(kind, m, d, 1'b0, 1'b0, NO_OUT);
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		while (bridge_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d effective and %0d ignored events over %0d profile shapes.",
			live_items, ignored, phase + 1);
		$display("Checked %0d output beats, %0d of them profile ends.", checked, ends_seen);
		if (err_count == 0)
			$display("** trapezoid_profile_hbridge_pwm: PASSED **");
		else
			$display("** trapezoid_profile_hbridge_pwm: FAILED **");
		$finish;
	end

endmodule
